// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TUN_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TUN_ASSERT(lbl, clk, rst, prop, msg)
`define TUN_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/tun_pkg.sv =====
package tun_pkg;

  localparam int COORD_BITS_DEF = 20;
  // magnitudes after normalising shift
  localparam int MAG_BITS       = 30;
  localparam int SQ_BITS        = 2 * MAG_BITS + 2;
  localparam int ROOT_BITS      = SQ_BITS / 2;
  localparam int SQ_REM_BITS    = ROOT_BITS + 3;
  localparam int Q_BITS         = 17;
  localparam int DIV_REM_BITS   = ROOT_BITS + 1;
  localparam int OUT_BITS       = 16;
  localparam logic [OUT_BITS:0] OUT_MAX = 17'd32767;

  typedef struct packed {
    logic en;
    logic valid;
  } tun_ctl_t;

endpackage

// ===== rtl/tun_if.sv =====
interface tun_in_if #(parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  modport source(output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink(input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] nx, ny, nz;
  logic               degenerate;
  modport source(output valid, nx, ny, nz, degenerate, input ready);
  modport sink(input valid, nx, ny, nz, degenerate, output ready);
endinterface

// ===== rtl/tun_sqrt_cell.sv =====
// One result bit of the integer square root per cell.
module tun_sqrt_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tun_pkg::tun_ctl_t                 ctl,
  input  logic [tun_pkg::SQ_BITS-1:0]       x,
  input  logic [tun_pkg::ROOT_BITS-1:0]     root,
  input  logic [tun_pkg::SQ_REM_BITS-1:0]   rem,
  input  logic [SIDE_W-1:0]                 side,
  output logic                              valid_fwd,
  output logic [tun_pkg::SQ_BITS-1:0]       x_fwd,
  output logic [tun_pkg::ROOT_BITS-1:0]     root_fwd,
  output logic [tun_pkg::SQ_REM_BITS-1:0]   rem_fwd,
  output logic [SIDE_W-1:0]                 side_fwd
);
  import tun_pkg::*;

  logic [SQ_REM_BITS-1:0] rem2, trial;
  logic                   ge;

  always_comb begin
    rem2  = {rem[SQ_REM_BITS-3:0], x[SQ_BITS-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    ge    = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_fwd <= 1'b0;
    end else if (ctl.en) begin
      valid_fwd <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x_fwd    <= {x[SQ_BITS-3:0], 2'b00};
      root_fwd <= {root[ROOT_BITS-2:0], ge};
      rem_fwd  <= ge ? rem2 - trial : rem2;
      side_fwd <= side;
    end
  end
endmodule

// ===== rtl/tun_div_cell.sv =====
// One quotient bit for each of the three components per cell.
module tun_div_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tun_pkg::tun_ctl_t                      ctl,
  input  logic [tun_pkg::ROOT_BITS-1:0]          len,
  input  logic [2:0][tun_pkg::DIV_REM_BITS-1:0]  rem,
  input  logic [2:0][tun_pkg::Q_BITS-1:0]        num,
  input  logic [2:0][tun_pkg::Q_BITS-1:0]        q,
  input  logic [SIDE_W-1:0]                      side,
  output logic                                   valid_fwd,
  output logic [tun_pkg::ROOT_BITS-1:0]          len_fwd,
  output logic [2:0][tun_pkg::DIV_REM_BITS-1:0]  rem_fwd,
  output logic [2:0][tun_pkg::Q_BITS-1:0]        num_fwd,
  output logic [2:0][tun_pkg::Q_BITS-1:0]        q_fwd,
  output logic [SIDE_W-1:0]                      side_fwd
);
  import tun_pkg::*;

  logic [2:0][DIV_REM_BITS-1:0] rem2, rem_next;
  logic [2:0]                   ge;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem2[k]     = {rem[k][DIV_REM_BITS-2:0], num[k][Q_BITS-1]};
      ge[k]       = (rem2[k] >= {1'b0, len});
      rem_next[k] = ge[k] ? rem2[k] - {1'b0, len} : rem2[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_fwd <= 1'b0;
    end else if (ctl.en) begin
      valid_fwd <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      len_fwd  <= len;
      side_fwd <= side;
      for (int k = 0; k < 3; k++) begin
        rem_fwd[k] <= rem_next[k];
        num_fwd[k] <= {num[k][Q_BITS-2:0], 1'b0};
        q_fwd[k]   <= {q[k][Q_BITS-2:0], ge[k]};
      end
    end
  end
endmodule

// ===== rtl/triangle_unit_normal_unit.sv =====
// Channel   Dir  Payload
// tri_in    in   ax ay az bx by bz cx cy cz, COORD_BITS signed each
// nrm_out   out  nx ny nz (16 signed, Q1.15), degenerate
//
// One item per cycle unless stalled. Items pass the front stages, the
// square-root chain (one root bit per cell), the divider chain (one
// quotient bit per cell) and the output register. Reset (rst, synchronous)
// clears every valid bit. A held result stalls the whole pipeline in step;
// tri_in.ready is high when the output register is empty or being taken.
module triangle_unit_normal_unit #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  tun_in_if.sink    tri_in,
  tun_out_if.source nrm_out
);
  import tun_pkg::*;
  `include "assert_macros.svh"

  localparam int ES   = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int EW   = COORD_BITS - ES + 1;
  localparam int PW   = 2 * EW;
  localparam int NW   = PW + 1;
  localparam int MW   = (PW > MAG_BITS) ? PW : MAG_BITS;
  localparam int SH_W = (MW > MAG_BITS) ? $clog2(MW - MAG_BITS + 1) : 1;
  localparam int SQ_SIDE = 4 + 3 * MAG_BITS;

  logic adv;
  logic out_valid;
  assign adv          = !out_valid || nrm_out.ready;
  assign tri_in.ready = adv;

  // edges
  logic v1;
  logic signed [2:0][EW-1:0] e1, e2;
  logic signed [COORD_BITS:0] d1x, d1y, d1z, d2x, d2y, d2z;

  function automatic logic signed [COORD_BITS:0] sub(
    input logic signed [COORD_BITS-1:0] p, input logic signed [COORD_BITS-1:0] q);
    sub = $signed({p[COORD_BITS-1], p}) - $signed({q[COORD_BITS-1], q});
  endfunction

  always_comb begin
    d1x = sub(tri_in.bx, tri_in.ax);
    d1y = sub(tri_in.by, tri_in.ay);
    d1z = sub(tri_in.bz, tri_in.az);
    d2x = sub(tri_in.cx, tri_in.ax);
    d2y = sub(tri_in.cy, tri_in.ay);
    d2z = sub(tri_in.cz, tri_in.az);
  end

  // products
  logic v2;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  assign e1x = e1[0];
  assign e1y = e1[1];
  assign e1z = e1[2];
  assign e2x = e2[0];
  assign e2y = e2[1];
  assign e2z = e2[2];

  // cross product
  logic v3;
  logic signed [NW-1:0] n0, n1, n2;

  // magnitudes
  logic v4;
  logic [2:0][MW-1:0] mag;
  logic [2:0]         sgn4;
  logic               deg4;

  // shift amount
  logic v5;
  logic [2:0][MW-1:0] mag5;
  logic [2:0]         sgn5;
  logic               deg5;
  logic [SH_W-1:0]    sh, sh_next;
  logic [MW-1:0]      mor;

  // normalised magnitudes
  logic v6;
  logic [2:0][MAG_BITS-1:0] m6;
  logic [2:0]               sgn6;
  logic                     deg6;

  // squares
  logic v7;
  logic [2:0][2*MAG_BITS-1:0] sq7;
  logic [2:0][MAG_BITS-1:0]   m7;
  logic [2:0]                 sgn7;
  logic                       deg7;

  // sum
  logic v8;
  logic [SQ_BITS-1:0]         sum8;
  logic [2:0][MAG_BITS-1:0]   m8;
  logic [2:0]                 sgn8;
  logic                       deg8;

  function automatic logic [NW-1:0] absn(input logic signed [NW-1:0] v);
    absn = v[NW-1] ? -v : v;
  endfunction

  always_comb begin
    mor     = mag[0] | mag[1] | mag[2];
    sh_next = '0;
    for (int j = MAG_BITS; j < MW; j++) begin
      if (mor[j]) sh_next = SH_W'(j - MAG_BITS + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v1 <= tri_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1[0] <= EW'(d1x >>> ES);
      e1[1] <= EW'(d1y >>> ES);
      e1[2] <= EW'(d1z >>> ES);
      e2[0] <= EW'(d2x >>> ES);
      e2[1] <= EW'(d2y >>> ES);
      e2[2] <= EW'(d2z >>> ES);

      p0 <= e1y * e2z;
      p1 <= e1z * e2y;
      p2 <= e1z * e2x;
      p3 <= e1x * e2z;
      p4 <= e1x * e2y;
      p5 <= e1y * e2x;

      n0 <= NW'(p0) - NW'(p1);
      n1 <= NW'(p2) - NW'(p3);
      n2 <= NW'(p4) - NW'(p5);

      mag[0] <= MW'(absn(n0));
      mag[1] <= MW'(absn(n1));
      mag[2] <= MW'(absn(n2));
      sgn4   <= {n2[NW-1], n1[NW-1], n0[NW-1]};
      deg4   <= (n0 == '0) && (n1 == '0) && (n2 == '0);

      mag5 <= mag;
      sgn5 <= sgn4;
      deg5 <= deg4;
      sh   <= sh_next;

      for (int k = 0; k < 3; k++) begin
        m6[k] <= MAG_BITS'(mag5[k] >> sh);
      end
      sgn6 <= sgn5;
      deg6 <= deg5;

      for (int k = 0; k < 3; k++) begin
        sq7[k] <= m6[k] * m6[k];
      end
      m7   <= m6;
      sgn7 <= sgn6;
      deg7 <= deg6;

      sum8 <= SQ_BITS'(sq7[0]) + SQ_BITS'(sq7[1]) + SQ_BITS'(sq7[2]);
      m8   <= m7;
      sgn8 <= sgn7;
      deg8 <= deg7;
    end
  end

  // square-root chain
  logic                   sq_v    [0:ROOT_BITS];
  logic [SQ_BITS-1:0]     sq_x    [0:ROOT_BITS];
  logic [ROOT_BITS-1:0]   sq_root [0:ROOT_BITS];
  logic [SQ_REM_BITS-1:0] sq_rem  [0:ROOT_BITS];
  logic [SQ_SIDE-1:0]     sq_side [0:ROOT_BITS];

  assign sq_v[0]    = v8;
  assign sq_x[0]    = sum8;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = {deg8, sgn8, m8};

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
    tun_ctl_t ctl;
    assign ctl.en    = adv;
    assign ctl.valid = sq_v[i];
    tun_sqrt_cell #(.SIDE_W(SQ_SIDE)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .x        (sq_x[i]),
      .root     (sq_root[i]),
      .rem      (sq_rem[i]),
      .side     (sq_side[i]),
      .valid_fwd(sq_v[i+1]),
      .x_fwd    (sq_x[i+1]),
      .root_fwd (sq_root[i+1]),
      .rem_fwd  (sq_rem[i+1]),
      .side_fwd (sq_side[i+1])
    );
  end

  // divider chain
  logic                          dv_v    [0:Q_BITS];
  logic [ROOT_BITS-1:0]          dv_len  [0:Q_BITS];
  logic [2:0][DIV_REM_BITS-1:0]  dv_rem  [0:Q_BITS];
  logic [2:0][Q_BITS-1:0]        dv_num  [0:Q_BITS];
  logic [2:0][Q_BITS-1:0]        dv_q    [0:Q_BITS];
  logic [3:0]                    dv_side [0:Q_BITS];
  logic [2:0][MAG_BITS-1:0]      m_root;
  logic [ROOT_BITS-1:0]          root_fin;

  assign root_fin   = sq_root[ROOT_BITS];
  assign m_root     = sq_side[ROOT_BITS][3*MAG_BITS-1:0];
  assign dv_v[0]    = sq_v[ROOT_BITS];
  assign dv_len[0]  = (root_fin == '0) ? ROOT_BITS'(1) : root_fin;
  assign dv_side[0] = sq_side[ROOT_BITS][SQ_SIDE-1 -: 4];
  assign dv_q[0]    = '0;

  // m * 2^16 split: top bits seed the remainder, the lowest bit leads the rest
  for (genvar k = 0; k < 3; k++) begin : g_seed
    assign dv_rem[0][k] = DIV_REM_BITS'(m_root[k] >> 1);
    assign dv_num[0][k] = {m_root[k][0], {(Q_BITS-1){1'b0}}};
  end

  for (genvar i = 0; i < Q_BITS; i++) begin : g_div
    tun_ctl_t ctl;
    assign ctl.en    = adv;
    assign ctl.valid = dv_v[i];
    tun_div_cell #(.SIDE_W(4)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .len      (dv_len[i]),
      .rem      (dv_rem[i]),
      .num      (dv_num[i]),
      .q        (dv_q[i]),
      .side     (dv_side[i]),
      .valid_fwd(dv_v[i+1]),
      .len_fwd  (dv_len[i+1]),
      .rem_fwd  (dv_rem[i+1]),
      .num_fwd  (dv_num[i+1]),
      .q_fwd    (dv_q[i+1]),
      .side_fwd (dv_side[i+1])
    );
  end

  // round half away, saturate, apply sign
  logic [2:0][OUT_BITS:0]         rnd;
  logic [2:0][OUT_BITS-1:0]       res;
  logic [2:0]                     sgn_f;
  logic [2:0][OUT_BITS-1:0]       nv;
  logic                           deg_out;

  assign sgn_f = dv_side[Q_BITS][2:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = (dv_q[Q_BITS][k] + Q_BITS'(1)) >> 1;
      if (rnd[k] > OUT_MAX) rnd[k] = OUT_MAX;
      res[k] = sgn_f[k] ? -rnd[k][OUT_BITS-1:0] : rnd[k][OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nv      <= res;
      deg_out <= dv_side[Q_BITS][3];
    end
  end

  assign nrm_out.valid      = out_valid;
  assign nrm_out.nx         = nv[0];
  assign nrm_out.ny         = nv[1];
  assign nrm_out.nz         = nv[2];
  assign nrm_out.degenerate = deg_out;

  `TUN_ASSERT(a_deg_zero, clk, rst, out_valid && deg_out |-> nv == '0, "degenerate item not zero")
  `TUN_ASSERT(a_nondeg_nonzero, clk, rst, out_valid && !deg_out |-> nv != '0, "zero normal on live item")
  `TUN_NEVER(a_no_min, clk, rst, out_valid && (nv[0] == 16'h8000 || nv[1] == 16'h8000 || nv[2] == 16'h8000), "component at -32768")
  `TUN_ASSERT(a_stall_hold, clk, rst, !adv |=> $stable(dv_v[Q_BITS]) && $stable(v8), "pipeline moved while stalled")
endmodule
